/* rtl/core/odq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered dither palette quantizer package
// Word types, register indexes, fixed widths and the Bayer offset table.
// ----------------------------------------------------------------------------
package odq_pkg;

	localparam int unsigned IDX_W   = 8;
	localparam int unsigned CNT_W   = 9;
	localparam int unsigned PX_W    = 13;
	localparam int unsigned SQ_W    = 26;
	localparam int unsigned DIST_W  = 28;
	localparam int unsigned CFG_W   = 7;
	localparam int unsigned CFGI_W  = 2;

	localparam logic [PX_W-1:0] FULL_SCALE = 13'd8160;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	localparam logic [CFGI_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_DITHER_ENABLE = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_PALETTE_COUNT = 2'd2;

	localparam logic [3:0] BAYER_LEVEL [16] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	typedef struct packed {
		logic        kind;
		logic [5:0]  entry_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic [5:0] chosen_entry;
		logic       mapped;
	} out_word_t;

	typedef struct packed {
		logic              kind;
		logic [5:0]        entry_index;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [7:0]        alpha;
		logic [2:0]        nch;
		logic [CNT_W-1:0]  cnt;
		logic [PX_W-1:0]   px_r;
		logic [PX_W-1:0]   px_g;
		logic [PX_W-1:0]   px_b;
		logic              found;
		logic [DIST_W-1:0] best_dist;
		logic [IDX_W-1:0]  best_idx;
		logic [7:0]        best_r;
		logic [7:0]        best_g;
		logic [7:0]        best_b;
	} chain_tok_t;

	function automatic logic signed [9:0] bayer_offset(input logic [1:0] x, input logic [1:0] y);
		logic signed [9:0] lv;
		lv = $signed({6'd0, BAYER_LEVEL[{y, x}]}) - 10'sd8;
		return lv * 10'sd51;
	endfunction

	function automatic logic [SQ_W-1:0] sq_diff(input logic [PX_W-1:0] px, input logic [7:0] pb);
		logic signed [PX_W+1:0] d;
		logic signed [PX_W+1:0] nd;
		logic [PX_W-1:0]        m;
		d  = $signed({2'b00, px}) - $signed({2'b00, pb, 5'b00000});
		nd = -d;
		m  = d[PX_W+1] ? nd[PX_W-1:0] : d[PX_W-1:0];
		return SQ_W'(m) * SQ_W'(m);
	endfunction

endpackage
`default_nettype wire

/* rtl/core/odq_head.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Quantizer head stage
// Registers the incoming word, applies the channel format and the dither.
// ----------------------------------------------------------------------------
module odq_head import odq_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             up_valid,
	input  wire in_word_t         up_word,
	input  wire logic [2:0]       channel_count,
	input  wire logic             dither_enable,
	input  wire logic [CFG_W-1:0] palette_count,
	output logic                  dn_valid_s1,
	output chain_tok_t            dn_tok_s1
);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	logic [2:0]        nch;
	logic [CNT_W-1:0]  cnt;
	logic [7:0]        g_eff;
	logic [7:0]        b_eff;
	logic signed [9:0] offset;
	logic [PX_W-1:0]   px_r;
	logic [PX_W-1:0]   px_g;
	logic [PX_W-1:0]   px_b;
	chain_tok_t        tok;

	function automatic logic [PX_W-1:0] dither_clamp(input logic [7:0] v,
			input logic signed [9:0] off);
		logic signed [PX_W+1:0] s;
		s = $signed({2'b00, v, 5'b00000}) + (PX_W+2)'(off);
		if (s < 0) begin
			return '0;
		end else if (s > $signed({2'b00, FULL_SCALE})) begin
			return FULL_SCALE;
		end
		return s[PX_W-1:0];
	endfunction

	always_comb begin
		if (channel_count == 3'd0) begin
			nch = 3'd1;
		end else if (channel_count > 3'd4) begin
			nch = 3'd4;
		end else begin
			nch = channel_count;
		end
		cnt    = (CNT_W'(palette_count) > DEPTH_CNT) ? DEPTH_CNT : CNT_W'(palette_count);
		g_eff  = (nch >= 3'd2) ? up_word.green : 8'd0;
		b_eff  = (nch >= 3'd3) ? up_word.blue : 8'd0;
		offset = dither_enable ? bayer_offset(up_word.pixel_x[1:0], up_word.pixel_y[1:0])
		                       : 10'sd0;
		px_r   = dither_clamp(up_word.red, offset);
		px_g   = dither_clamp(g_eff, offset);
		px_b   = dither_clamp(b_eff, offset);

		tok             = '0;
		tok.kind        = up_word.kind;
		tok.entry_index = up_word.entry_index;
		tok.red         = up_word.red;
		tok.green       = up_word.green;
		tok.blue        = up_word.blue;
		tok.alpha       = up_word.alpha;
		tok.nch         = nch;
		tok.cnt         = cnt;
		tok.px_r        = px_r;
		tok.px_g        = px_g;
		tok.px_b        = px_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid_s1 <= 1'b0;
		end else if (adv) begin
			dn_valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dn_tok_s1 <= tok;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/odq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Palette cell
// Holds one palette entry, captures it from a passing load word and folds
// its distance to a passing pixel into the running best match.
// ----------------------------------------------------------------------------
module odq_cell import odq_pkg::*; #(
	parameter int unsigned CELL_INDEX = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic       up_valid,
	input  wire chain_tok_t up_tok,
	output logic            dn_valid_s2,
	output chain_tok_t      dn_tok_s2
);

	localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(CELL_INDEX);
	localparam logic [CNT_W-1:0] CELL_CNT = CNT_W'(CELL_INDEX);

	logic [23:0]       entry_q;
	logic              valid_s1;
	chain_tok_t        tok_s1;
	logic              live_s1;
	logic [23:0]       ent_s1;
	logic [SQ_W-1:0]   sq_r_s1;
	logic [SQ_W-1:0]   sq_g_s1;
	logic [SQ_W-1:0]   sq_b_s1;
	logic [DIST_W-1:0] distance;
	logic              take;
	chain_tok_t        tok_next;

	always_ff @(posedge clk) begin
		if (adv && up_valid && up_tok.kind == KIND_LOAD &&
				IDX_W'(up_tok.entry_index) == CELL_IDX) begin
			entry_q <= {up_tok.blue, up_tok.green, up_tok.red};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			dn_valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1    <= up_valid;
			dn_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1    <= up_tok;
			live_s1   <= (up_tok.kind == KIND_PIXEL) && (CELL_CNT < up_tok.cnt);
			ent_s1    <= entry_q;
			sq_r_s1   <= sq_diff(up_tok.px_r, entry_q[7:0]);
			sq_g_s1   <= sq_diff(up_tok.px_g, entry_q[15:8]);
			sq_b_s1   <= sq_diff(up_tok.px_b, entry_q[23:16]);
			dn_tok_s2 <= tok_next;
		end
	end

	always_comb begin
		distance = DIST_W'(sq_r_s1) + DIST_W'(sq_g_s1) + DIST_W'(sq_b_s1);
		take     = live_s1 && (!tok_s1.found || distance < tok_s1.best_dist);
		tok_next = tok_s1;
		if (take) begin
			tok_next.found     = 1'b1;
			tok_next.best_dist = distance;
			tok_next.best_idx  = CELL_IDX;
			tok_next.best_r    = ent_s1[7:0];
			tok_next.best_g    = ent_s1[15:8];
			tok_next.best_b    = ent_s1[23:16];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/odq_tail.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Quantizer output stage
// Drops load words and formats the result word of each pixel.
// ----------------------------------------------------------------------------
module odq_tail import odq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic       up_valid,
	input  wire chain_tok_t up_tok,
	output logic            result_valid_q,
	output out_word_t       result_word_q
);

	out_word_t word;

	always_comb begin
		word           = '0;
		word.out_alpha = (up_tok.nch == 3'd4) ? up_tok.alpha : 8'd0;
		if (up_tok.found) begin
			word.out_red      = up_tok.best_r;
			word.out_green    = (up_tok.nch >= 3'd2) ? up_tok.best_g : 8'd0;
			word.out_blue     = (up_tok.nch >= 3'd3) ? up_tok.best_b : 8'd0;
			word.chosen_entry = up_tok.best_idx[5:0];
			word.mapped       = 1'b1;
		end else begin
			word.out_red   = up_tok.red;
			word.out_green = (up_tok.nch >= 3'd2) ? up_tok.green : 8'd0;
			word.out_blue  = (up_tok.nch >= 3'd3) ? up_tok.blue : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= up_valid && (up_tok.kind == KIND_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_word_q <= word;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/ordered_dither_palette_quantizer_top.sv */
// An accepted pixel word is registered in the head, in each cell and in the tail on its way to its result word.
// Throughput: one word per cycle; the whole cell chain advances together and holds
// while a result word is stalled.
// Load words take the same path and write their cell as they pass; they give no result.
// Reset returns the configuration to its defaults and clears all valid flags;
// palette cells are not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered dither palette quantizer
// Maps each pixel word to the nearest color of a palette held in a chain of
// cells, with optional 4x4 ordered dither ahead of the search.
// ----------------------------------------------------------------------------
module ordered_dither_palette_quantizer_top import odq_pkg::*; #(
	parameter int unsigned PALETTE_DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [CFGI_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              pixel_valid,
	output logic                   pixel_stall,
	input  wire in_word_t          pixel_word,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output out_word_t              result_word
);

	logic [2:0]       channel_count_q;
	logic             dither_enable_q;
	logic [CFG_W-1:0] palette_count_q;
	logic             adv;
	logic             link_valid [PALETTE_DEPTH+1];
	chain_tok_t       link_tok [PALETTE_DEPTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= 3'd4;
			dither_enable_q <= 1'b0;
			palette_count_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == CFG_CHANNEL_COUNT) begin
				channel_count_q <= cfg_data[2:0];
			end else if (cfg_index == CFG_DITHER_ENABLE) begin
				dither_enable_q <= cfg_data[0];
			end else if (cfg_index == CFG_PALETTE_COUNT) begin
				palette_count_q <= cfg_data;
			end
		end
	end

	assign adv         = !result_valid || !result_stall;
	assign pixel_stall = !adv;

	odq_head #(
		.DEPTH(PALETTE_DEPTH)
	) u_head (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.up_valid     (pixel_valid),
		.up_word      (pixel_word),
		.channel_count(channel_count_q),
		.dither_enable(dither_enable_q),
		.palette_count(palette_count_q),
		.dn_valid_s1  (link_valid[0]),
		.dn_tok_s1    (link_tok[0])
	);

	for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
		odq_cell #(
			.CELL_INDEX(g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.up_valid   (link_valid[g]),
			.up_tok     (link_tok[g]),
			.dn_valid_s2(link_valid[g+1]),
			.dn_tok_s2  (link_tok[g+1])
		);
	end

	odq_tail u_tail (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.up_valid      (link_valid[PALETTE_DEPTH]),
		.up_tok        (link_tok[PALETTE_DEPTH]),
		.result_valid_q(result_valid),
		.result_word_q (result_word)
	);

endmodule
`default_nettype wire

/* rtl/core/odq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Quantizer port checker
// Watches the top level ports for flow control and result word consistency.
// ----------------------------------------------------------------------------
module odq_checker import odq_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      pixel_stall,
	input wire logic      result_valid,
	input wire logic      result_stall,
	input wire out_word_t result_word
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_word))
		else $error("Stalled result word changed.");

	a_stall_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall == (result_valid && result_stall))
		else $error("Input stall does not match the output backpressure.");

	a_unmapped_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.mapped |-> result_word.chosen_entry == 6'd0)
		else $error("Passthrough word carries a nonzero entry.");

	a_idle_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !result_valid)
		else $error("Result word valid right after reset.");

endmodule

bind ordered_dither_palette_quantizer_top odq_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_stall (pixel_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result_word (result_word)
);
`default_nettype wire
